@@ rtl/pal_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and codes for the positional array list: the field types of
// the request and response beats, the operation codes and the status codes.
// ----------------------------------------------------------------------------
package pal_pkg;

   localparam int POS_W   = 6;
   localparam int VALUE_W = 32;

   typedef logic [1:0]               func_type;
   typedef logic [POS_W-1:0]         position_type;
   typedef logic signed [VALUE_W-1:0] value_type;

   localparam func_type FUNC_READ   = 2'd0;
   localparam func_type FUNC_INSERT = 2'd1;
   localparam func_type FUNC_REMOVE = 2'd2;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_EMPTY = 3'd1,
      ST_FULL  = 3'd2,
      ST_RANGE = 3'd3,
      ST_NONE  = 3'd4
   } status_type;

endpackage

@@ rtl/pal_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_if
// Request and response channels of the positional array list. Each carries
// valid, ready and the payload of one beat.
// ----------------------------------------------------------------------------
interface pal_req_if;
   import pal_pkg::*;

   logic         valid;
   logic         ready;
   func_type     func;
   position_type position;
   value_type    value;

   modport source (output valid, output func, output position, output value, input ready);
   modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface pal_rsp_if;
   import pal_pkg::*;

   logic         valid;
   logic         ready;
   status_type   status;
   value_type    read_value;
   position_type taken_position;
   position_type element_count;

   modport source (output valid, output status, output read_value, output taken_position,
                   output element_count, input ready);
   modport sink   (input valid, input status, input read_value, input taken_position,
                   input element_count, output ready);
endinterface

@@ rtl/positional_array_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list
// A read goes through S_READ and S_FINISH; an insert shifts the tail up
// (S_SHIFT, S_DRAIN), writes the new value (S_PUT) and finishes; an append
// goes straight to S_PUT. A remove shifts the tail down unless it removes
// the last element. One request at a time; the shift loop over the element
// memory moves one element per cycle through its single read and write port.
// Reset empties the list at once; the element memory itself is not cleared.
// ----------------------------------------------------------------------------
module positional_array_list #(
   parameter int CAPACITY    = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   pal_req_if.sink          req_bus,
   pal_rsp_if.source        rsp_bus
);
   import pal_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam position_type CAP_POS = position_type'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SHIFT,
      S_DRAIN,
      S_PUT,
      S_FINISH
   } state_type;

   state_type              state_ff;
   logic [CNT_W-1:0]       count_ff;
   func_type               func_ff;
   position_type           pos_ff;
   value_type              value_ff;
   status_type             status_ff;
   position_type           taken_ff;
   logic [CNT_W-1:0]       src_ff;
   logic [CNT_W-1:0]       last_ff;
   logic                   pend_ff;
   logic [IDX_W-1:0]       pend_dst_ff;

   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   value_type              rsp_read_ff;
   position_type           rsp_taken_ff;
   position_type           rsp_count_ff;

   logic signed [VALUE_WIDTH-1:0] store_ff [CAPACITY];
   logic signed [VALUE_WIDTH-1:0] rdata_ff;

   // Decode of the request beat.
   status_type             status_in;
   position_type           taken_in;
   state_type              start_in;
   logic [CNT_W-1:0]       src_in;
   logic [CNT_W-1:0]       last_in;

   position_type           count_pos;
   logic                   pos_ok;
   logic                   accept;
   logic                   slot_free;
   logic                   is_insert;
   logic [CNT_W-1:0]       dst_calc;
   logic [CNT_W-1:0]       count_next;

   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic signed [VALUE_WIDTH-1:0] mem_wdata;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;

   assign accept    = req_bus.valid && req_bus.ready;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign count_pos = position_type'(count_ff);
   assign pos_ok    = (req_bus.position != '0) && (req_bus.position <= CAP_POS);
   assign is_insert = (func_ff == FUNC_INSERT);

   always_comb begin
      status_in = ST_OK;
      taken_in  = '0;
      start_in  = S_FINISH;
      src_in    = '0;
      last_in   = '0;
      unique case (req_bus.func)
         FUNC_READ: begin
            priority if (count_ff == '0) status_in = ST_EMPTY;
            else if (!pos_ok) status_in = ST_RANGE;
            else if (req_bus.position > count_pos) status_in = ST_NONE;
            else start_in = S_READ;
         end
         FUNC_INSERT: begin
            priority if (count_ff == CNT_W'(CAPACITY)) status_in = ST_FULL;
            else if (!pos_ok) status_in = ST_RANGE;
            else if (req_bus.position <= count_pos) begin
               // Move the tail up, from the last element down to the slot.
               taken_in = req_bus.position;
               start_in = S_SHIFT;
               src_in   = count_ff - 1'b1;
               last_in  = CNT_W'(req_bus.position - 1'b1);
            end else begin
               taken_in = count_pos + 1'b1;
               start_in = S_PUT;
            end
         end
         FUNC_REMOVE: begin
            priority if (count_ff == '0) status_in = ST_EMPTY;
            else if (!pos_ok) status_in = ST_RANGE;
            else if (req_bus.position > count_pos) status_in = ST_NONE;
            else if (req_bus.position < count_pos) begin
               start_in = S_SHIFT;
               src_in   = CNT_W'(req_bus.position);
               last_in  = count_ff - 1'b1;
            end
         end
         default: ;
      endcase
   end

   // The shift runs as a two-step pipeline: the element read in one cycle
   // is written to its neighbor in the next, while the following one is read.
   always_comb begin
      dst_calc  = is_insert ? (src_ff + 1'b1) : (src_ff - 1'b1);
      mem_we    = ((state_ff == S_SHIFT) && pend_ff) || (state_ff == S_DRAIN);
      mem_waddr = pend_dst_ff;
      mem_wdata = rdata_ff;
      if (state_ff == S_PUT) begin
         mem_we    = 1'b1;
         mem_waddr = IDX_W'(taken_ff - 1'b1);
         mem_wdata = VALUE_WIDTH'(value_ff);
      end
      rd_en   = (state_ff == S_READ) || (state_ff == S_SHIFT);
      rd_addr = (state_ff == S_READ) ? IDX_W'(pos_ff - 1'b1) : src_ff[IDX_W-1:0];
   end

   always_comb begin
      count_next = count_ff;
      if (status_ff == ST_OK) begin
         if (func_ff == FUNC_INSERT) count_next = count_ff + 1'b1;
         else if (func_ff == FUNC_REMOVE) count_next = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rdata_ff <= store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= start_in;
                  pend_ff  <= 1'b0;
               end
            end
            S_READ: state_ff <= S_FINISH;
            S_SHIFT: begin
               pend_ff     <= 1'b1;
               pend_dst_ff <= dst_calc[IDX_W-1:0];
               if (src_ff == last_ff) begin
                  state_ff <= S_DRAIN;
               end else begin
                  src_ff <= is_insert ? (src_ff - 1'b1) : (src_ff + 1'b1);
               end
            end
            S_DRAIN: begin
               pend_ff  <= 1'b0;
               state_ff <= is_insert ? S_PUT : S_FINISH;
            end
            S_PUT: state_ff <= S_FINISH;
            S_FINISH: begin
               if (slot_free) begin
                  count_ff <= count_next;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase

         if ((state_ff == S_FINISH) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (accept) begin
         func_ff   <= req_bus.func;
         pos_ff    <= req_bus.position;
         value_ff  <= req_bus.value;
         status_ff <= status_in;
         taken_ff  <= taken_in;
         src_ff    <= src_in;
         last_ff   <= last_in;
      end

      if ((state_ff == S_FINISH) && slot_free) begin
         rsp_status_ff <= status_ff;
         rsp_read_ff   <= ((func_ff == FUNC_READ) && (status_ff == ST_OK)) ?
                          VALUE_W'(rdata_ff) : '0;
         rsp_taken_ff  <= taken_ff;
         rsp_count_ff  <= position_type'(count_next);
      end
   end

   assign req_bus.ready          = (state_ff == S_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.read_value     = rsp_read_ff;
   assign rsp_bus.taken_position = rsp_taken_ff;
   assign rsp_bus.element_count  = rsp_count_ff;

   // The element count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   // A pending shift write never lands on the entry being read in that cycle.
   a_shift_no_collide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && pend_ff) |-> (pend_dst_ff != rd_addr))
      else $error("shift write collides with shift read");

   // A successful insert grows the list by exactly one element.
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && slot_free && status_ff == ST_OK &&
       func_ff == FUNC_INSERT) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not add one element");

   // Finishing an item always hands a beat to the response register.
   a_finish_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && slot_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished item produced no response beat");

endmodule
